>>> rtl/tls_pkg.sv
// Shared types and constants for the traffic light sequencer.
package tls_pkg;

  // Width of every phase-length register and of the register index.
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  // Default width of the per-phase tick counter.
  localparam int TICK_BITS_DEFAULT = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_RED_TICKS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_YELLOW_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GREEN_TICKS  = 2'd2;

  // Phase lengths after reset, in ticks.
  localparam logic [CfgW-1:0] RED_TICKS_RESET    = 16'd2000;
  localparam logic [CfgW-1:0] YELLOW_TICKS_RESET = 16'd1000;
  localparam logic [CfgW-1:0] GREEN_TICKS_RESET  = 16'd2000;

  typedef enum logic [2:0] {
    PH_RED        = 3'd0,
    PH_RED_YELLOW = 3'd1,
    PH_YELLOW     = 3'd2,
    PH_GREEN      = 3'd3,
    PH_WARN       = 3'd4
  } phase_e;

  // One result word as it leaves the block.
  typedef struct packed {
    logic   red_lamp;
    logic   yellow_lamp;
    logic   green_lamp;
    phase_e phase;
    logic   awaiting_release;
  } result_t;

endpackage

>>> rtl/tls_step.sv
// Next-state and lamp decoding logic for one tick of the traffic light sequencer.
module tls_step #(
  parameter int TickBits = tls_pkg::TICK_BITS_DEFAULT
) (
  input  tls_pkg::phase_e          phase_i,
  input  logic [TickBits-1:0]      elapsed_i,
  input  logic                     wait_i,
  input  logic                     button_i,
  input  logic [tls_pkg::CfgW-1:0] red_ticks_i,
  input  logic [tls_pkg::CfgW-1:0] yellow_ticks_i,
  input  logic [tls_pkg::CfgW-1:0] green_ticks_i,
  output tls_pkg::phase_e          phase_o,
  output logic [TickBits-1:0]      elapsed_o,
  output logic                     wait_o,
  output tls_pkg::result_t         result_o
);

  // Compare width covers both the counter and the length registers.
  localparam int CmpW = (TickBits > tls_pkg::CfgW) ? TickBits : tls_pkg::CfgW;

  logic [tls_pkg::CfgW-1:0] lim_raw;
  logic [CmpW-1:0]          lim_ext;
  logic [CmpW-1:0]          max_ext;
  logic [CmpW-1:0]          lim;
  logic [TickBits-1:0]      cnt;
  logic                     timeout;
  tls_pkg::phase_e          ph_timeout;
  tls_pkg::phase_e          ph_press;

  always_comb begin
    case (phase_i)
      tls_pkg::PH_GREEN:      lim_raw = green_ticks_i;
      tls_pkg::PH_RED_YELLOW,
      tls_pkg::PH_YELLOW,
      tls_pkg::PH_WARN:       lim_raw = yellow_ticks_i;
      default:                lim_raw = red_ticks_i;
    endcase
  end

  // A zero length acts as one tick; a length beyond the counter is clamped.
  always_comb begin
    lim_ext = CmpW'(lim_raw);
    max_ext = CmpW'({TickBits{1'b1}});
    if (lim_raw == '0) begin
      lim = CmpW'(1);
    end else if (lim_ext > max_ext) begin
      lim = max_ext;
    end else begin
      lim = lim_ext;
    end
  end

  assign cnt     = elapsed_i + TickBits'(1);
  assign timeout = (CmpW'(cnt) >= lim);

  always_comb begin
    case (phase_i)
      tls_pkg::PH_RED_YELLOW: ph_timeout = tls_pkg::PH_GREEN;
      tls_pkg::PH_YELLOW:     ph_timeout = tls_pkg::PH_GREEN;
      tls_pkg::PH_GREEN:      ph_timeout = tls_pkg::PH_RED;
      tls_pkg::PH_WARN:       ph_timeout = tls_pkg::PH_RED;
      default:                ph_timeout = tls_pkg::PH_YELLOW;
    endcase
  end

  always_comb begin
    case (phase_i)
      tls_pkg::PH_RED_YELLOW: ph_press = tls_pkg::PH_GREEN;
      tls_pkg::PH_YELLOW:     ph_press = tls_pkg::PH_GREEN;
      tls_pkg::PH_GREEN:      ph_press = tls_pkg::PH_WARN;
      tls_pkg::PH_WARN:       ph_press = tls_pkg::PH_RED;
      default:                ph_press = tls_pkg::PH_RED_YELLOW;
    endcase
  end

  always_comb begin
    phase_o   = phase_i;
    elapsed_o = elapsed_i;
    wait_o    = wait_i;
    if (wait_i) begin
      if (!button_i) begin
        wait_o    = 1'b0;
        phase_o   = ph_press;
        elapsed_o = '0;
      end
    end else if (button_i) begin
      wait_o = 1'b1;
    end else if (timeout) begin
      phase_o   = ph_timeout;
      elapsed_o = '0;
    end else begin
      elapsed_o = cnt;
    end
  end

  always_comb begin
    result_o.phase            = phase_o;
    result_o.awaiting_release = wait_o;
    result_o.red_lamp         = 1'b0;
    result_o.yellow_lamp      = 1'b0;
    result_o.green_lamp       = 1'b0;
    case (phase_o)
      tls_pkg::PH_RED_YELLOW: begin
        result_o.red_lamp    = 1'b1;
        result_o.yellow_lamp = 1'b1;
      end
      tls_pkg::PH_YELLOW,
      tls_pkg::PH_WARN:       result_o.yellow_lamp = 1'b1;
      tls_pkg::PH_GREEN:      result_o.green_lamp  = 1'b1;
      default:                result_o.red_lamp    = 1'b1;
    endcase
  end

endmodule

>>> rtl/traffic_light_sequencer_unit.sv
// Top level of the traffic light sequencer with pedestrian button.
//
// Each input word is one millisecond tick carrying the sampled pedestrian
// button, and each tick produces exactly one result word with the lamp
// states, the phase code and the hold-for-release flag as they stand after
// that tick. The block walks red, yellow, green on timeouts; a press holds
// the lamps until the button is released and then jumps ahead (red goes to
// red plus yellow and on to green, green goes to warning yellow and on to
// red, any other phase just ends). The phase state is updated at the edge
// that accepts a tick, and the result is captured in the same edge into a
// single output register, so one word is taken every clock cycle while the
// receiver keeps up; a valid result appears in the cycle after acceptance.
// The input side stays ready while the output register is empty or is being
// drained in the same cycle; a result that waits for the receiver holds off
// the next tick for as long as it waits. The three phase lengths must be
// written through the configuration port only while the block is idle; the
// block itself does not enforce this. A zero length acts as one tick and
// lengths beyond the counter width are clamped to the largest count.
module traffic_light_sequencer_unit #(
  parameter int TICK_BITS = tls_pkg::TICK_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [tls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tls_pkg::CfgW-1:0]    cfg_data_i,
  // Tick input channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        button_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        red_lamp_o,
  output logic                        yellow_lamp_o,
  output logic                        green_lamp_o,
  output logic [2:0]                  phase_o,
  output logic                        awaiting_release_o
);

  // Phase length registers.
  logic [tls_pkg::CfgW-1:0] red_ticks_q;
  logic [tls_pkg::CfgW-1:0] yellow_ticks_q;
  logic [tls_pkg::CfgW-1:0] green_ticks_q;

  // Sequencer state.
  tls_pkg::phase_e      phase_q, phase_d;
  logic [TICK_BITS-1:0] elapsed_q, elapsed_d;
  logic                 wait_q, wait_d;

  // Output register.
  tls_pkg::result_t result_q, result_d;
  logic             out_valid_q;

  logic in_acc;

  // The output register can take a new word when it is empty or drains now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_ticks_q    <= tls_pkg::RED_TICKS_RESET;
      yellow_ticks_q <= tls_pkg::YELLOW_TICKS_RESET;
      green_ticks_q  <= tls_pkg::GREEN_TICKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tls_pkg::REG_RED_TICKS:    red_ticks_q    <= cfg_data_i;
        tls_pkg::REG_YELLOW_TICKS: yellow_ticks_q <= cfg_data_i;
        tls_pkg::REG_GREEN_TICKS:  green_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tls_step #(
    .TickBits (TICK_BITS)
  ) u_step (
    .phase_i        (phase_q),
    .elapsed_i      (elapsed_q),
    .wait_i         (wait_q),
    .button_i       (button_i),
    .red_ticks_i    (red_ticks_q),
    .yellow_ticks_i (yellow_ticks_q),
    .green_ticks_i  (green_ticks_q),
    .phase_o        (phase_d),
    .elapsed_o      (elapsed_d),
    .wait_o         (wait_d),
    .result_o       (result_d)
  );

  // State advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tls_pkg::PH_RED;
      elapsed_q <= '0;
      wait_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      wait_q    <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign red_lamp_o         = result_q.red_lamp;
  assign yellow_lamp_o      = result_q.yellow_lamp;
  assign green_lamp_o       = result_q.green_lamp;
  assign phase_o            = result_q.phase;
  assign awaiting_release_o = result_q.awaiting_release;

  // A pending result always describes the current sequencer state.
  a_result_matches_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.phase == phase_q && result_q.awaiting_release == wait_q)
  ) else $error("pending result does not match sequencer state");

  // A tick with the button still held during the release wait keeps the phase.
  a_hold_while_pressed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wait_q && button_i) |=> (wait_q && phase_q == $past(phase_q))
  ) else $error("phase changed while waiting for button release");

  // The release tick leaves the wait and restarts the tick count.
  a_release_restarts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wait_q && !button_i) |=> (!wait_q && elapsed_q == '0)
  ) else $error("button release did not restart the phase");

  // A press outside the wait freezes the count and holds the phase.
  a_press_freezes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !wait_q && button_i) |=>
      (wait_q && phase_q == $past(phase_q) && elapsed_q == $past(elapsed_q))
  ) else $error("press did not freeze the phase");

endmodule
